>>> hw/rtl/hermite_rate_resampler_defines.svh
// Assertion macros used by the checker file of the resampler.
`ifndef HERMITE_RATE_RESAMPLER_DEFINES_SVH
`define HERMITE_RATE_RESAMPLER_DEFINES_SVH

// Same-cycle implication with a reset guard.
`define HRR_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("hrr check failed");

// Next-cycle implication with a reset guard.
`define HRR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("hrr check failed");

`endif

>>> hw/rtl/hrr_pkg.sv
package hrr_pkg;

  localparam int SAMPLE_W            = 16;
  localparam int STEP_W              = 23;
  localparam int STEP_FRAC           = 20;
  localparam int FRAC_W              = 16;
  localparam int HIST_N              = 8;
  localparam int MAX_RES             = 4;
  localparam int T_W                 = 22;
  localparam int CHANNELS_DEF        = 2;
  localparam int PHASE_FRAC_BITS_DEF = 20;
  localparam int QUEUE_DEPTH_DEF     = 4;

  localparam logic [STEP_W-1:0] STEP_MIN = 23'd262144;
  localparam logic [STEP_W-1:0] STEP_MAX = 23'd4194304;

  localparam logic signed [SAMPLE_W-1:0] SAT_HI = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAT_LO = 16'sh8000;

  typedef logic [HIST_N-1:0][SAMPLE_W-1:0] hist_t;

  typedef struct packed {
    hist_t             hist;
    logic              last;
    logic [FRAC_W-1:0] frac;
  } job_t;

endpackage

>>> hw/rtl/hrr_front.sv
module hrr_front #(
  parameter int CHANNELS        = hrr_pkg::CHANNELS_DEF,
  parameter int PHASE_FRAC_BITS = hrr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hrr_pkg::SAMPLE_W-1:0]     sample_left,
  input  logic [hrr_pkg::SAMPLE_W-1:0]     sample_right,
  input  logic [hrr_pkg::STEP_W-1:0]       step,
  output logic                             push,
  output hrr_pkg::job_t                    job,
  input  logic                             full
);
  import hrr_pkg::*;

  localparam int PW  = PHASE_FRAC_BITS + 4;
  localparam int SHL = (PHASE_FRAC_BITS >= STEP_FRAC) ? PHASE_FRAC_BITS - STEP_FRAC : 0;
  localparam int SHR = (PHASE_FRAC_BITS >= STEP_FRAC) ? 0 : STEP_FRAC - PHASE_FRAC_BITS;
  localparam logic [PW-1:0] ONE = PW'(1) << PHASE_FRAC_BITS;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_EMIT = 2'b10
  } fstate_t;

  fstate_t          state;
  hist_t            hist;
  logic [PW-1:0]    phase;
  logic [PW-1:0]    step_q;
  logic [2:0]       cnt;
  logic [1:0]       frames_seen;

  logic [STEP_W-1:0]   step_sat;
  logic [PW-1:0]       step_calc;
  logic [PW-1:0]       phase_sum;
  logic                go;
  logic [SAMPLE_W-1:0] right_in;

  always_comb begin
    if (step < STEP_MIN) begin
      step_sat = STEP_MIN;
    end else if (step > STEP_MAX) begin
      step_sat = STEP_MAX;
    end else begin
      step_sat = step;
    end
    if (PHASE_FRAC_BITS >= STEP_FRAC) begin
      step_calc = PW'(step_sat) << SHL;
    end else begin
      step_calc = PW'(step_sat >> SHR);
    end
  end

  assign right_in  = (CHANNELS > 1) ? sample_right : '0;
  assign in_ready  = (state == F_IDLE);
  assign phase_sum = phase + step_q;
  assign go        = (phase < ONE) && (cnt < 3'(MAX_RES));
  assign push      = (state == F_EMIT) && go && !full;

  always_comb begin
    job.hist = hist;
    job.frac = phase[PHASE_FRAC_BITS-1 -: FRAC_W];
    job.last = (phase_sum >= ONE) || (cnt == 3'(MAX_RES - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      hist        <= '0;
      phase       <= '0;
      step_q      <= '0;
      cnt         <= '0;
      frames_seen <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            hist   <= {right_in, sample_left, hist[HIST_N-1:2]};
            step_q <= step_calc;
            cnt    <= '0;
            if (frames_seen < 2'd2) begin
              frames_seen <= frames_seen + 2'd1;
            end else begin
              frames_seen <= 2'd3;
              state       <= F_EMIT;
            end
          end
        end
        F_EMIT: begin
          if (go) begin
            if (!full) begin
              phase <= phase_sum;
              cnt   <= cnt + 3'd1;
            end
          end else begin
            phase <= (phase >= ONE) ? phase - ONE : '0;
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/hrr_queue.sv
module hrr_queue #(
  parameter int DEPTH = hrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hrr_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output hrr_pkg::job_t rd_job
);
  import hrr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t               mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign full   = (count == (PTR_W+1)'(DEPTH));
  assign valid  = (count != '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

>>> hw/rtl/hrr_back.sv
module hrr_back #(
  parameter int CHANNELS = hrr_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  hrr_pkg::job_t                 job_in,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hrr_pkg::SAMPLE_W-1:0]  out_left,
  output logic [hrr_pkg::SAMPLE_W-1:0]  out_right,
  output logic                          run_end
);
  import hrr_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PROD_W = T_W + FRAC_W + 1;
  localparam int S_W    = T_W + 1;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_COEF = 5'b00010,
    B_MUL  = 5'b00100,
    B_FIN  = 5'b01000,
    B_DONE = 5'b10000
  } bstate_t;

  bstate_t                    state;
  job_t                       job;
  logic [CH_W-1:0]            ch;
  logic [1:0]                 k;
  logic signed [T_W-1:0]      coef_a;
  logic signed [T_W-1:0]      coef_b;
  logic signed [T_W-1:0]      coef_c;
  logic signed [SAMPLE_W-1:0] x0;
  logic signed [PROD_W-1:0]   prod;
  logic [1:0][SAMPLE_W-1:0]   res;

  logic signed [T_W-1:0]      em1, e0, e1, e2;
  logic signed [T_W-1:0]      fl;
  logic signed [T_W-1:0]      mul_in;
  logic signed [FRAC_W:0]     frac_s;
  logic signed [PROD_W-1:0]   prod_calc;
  logic signed [S_W-1:0]      sum_s;
  logic signed [S_W-1:0]      rnd;
  logic signed [S_W-1:0]      half;
  logic [SAMPLE_W-1:0]        y;

  always_comb begin
    em1 = T_W'($signed(job.hist[3'(ch)]));
    e0  = T_W'($signed(job.hist[3'(ch) + 3'd2]));
    e1  = T_W'($signed(job.hist[3'(ch) + 3'd4]));
    e2  = T_W'($signed(job.hist[3'(ch) + 3'd6]));
  end

  assign fl     = $signed(prod[FRAC_W +: T_W]);
  assign frac_s = $signed({1'b0, job.frac});

  always_comb begin
    case (k)
      2'd0:    mul_in = coef_c;
      2'd1:    mul_in = fl + coef_b;
      default: mul_in = fl + coef_a;
    endcase
  end

  assign prod_calc = mul_in * frac_s;

  always_comb begin
    sum_s = S_W'(fl) + S_W'(x0) + S_W'(x0);
    rnd   = sum_s + $signed({{(S_W-1){1'b0}}, sum_s[S_W-1]});
    half  = rnd >>> 1;
    if (half > S_W'(SAT_HI)) begin
      y = SAT_HI;
    end else if (half < S_W'(SAT_LO)) begin
      y = SAT_LO;
    end else begin
      y = half[SAMPLE_W-1:0];
    end
  end

  assign pop = (state == B_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      ch        <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != B_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            job   <= job_in;
            res   <= '0;
            ch    <= '0;
            state <= B_COEF;
          end
        end
        B_COEF: begin
          coef_a <= e1 - em1;
          coef_b <= (em1 <<< 1) - (e0 <<< 2) - e0 + (e1 <<< 2) - e2;
          coef_c <= e2 - em1 + ((e0 - e1) <<< 1) + (e0 - e1);
          x0     <= e0[SAMPLE_W-1:0];
          k      <= '0;
          state  <= B_MUL;
        end
        B_MUL: begin
          prod <= prod_calc;
          k    <= k + 2'd1;
          if (k == 2'd2) begin
            state <= B_FIN;
          end
        end
        B_FIN: begin
          res[ch] <= y;
          if (ch == CH_W'(CHANNELS - 1)) begin
            state <= B_DONE;
          end else begin
            ch    <= ch + CH_W'(1);
            state <= B_COEF;
          end
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_left  <= res[0];
            out_right <= (CHANNELS > 1) ? res[1] : '0;
            run_end   <= job.last;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/hermite_rate_resampler.sv
// The interpolator uses one shared multiplier that runs three Horner steps per channel,
// and takes a new job from the queue only after the last result is in the output register.
// The input side takes each of the first two frames while it primes the history, and
// after that stays busy with each frame until its results are pushed; a full queue stalls it.
// Synchronous reset clears the history to zero, the phase, the queue and the output valid flag.
module hermite_rate_resampler #(
  parameter int CHANNELS        = hrr_pkg::CHANNELS_DEF,
  parameter int PHASE_FRAC_BITS = hrr_pkg::PHASE_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH     = hrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // sample_left, sample_right, step, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_left, out_right
  output logic        m_tlast
);
  import hrr_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  job_valid;
  job_t  wr_job;
  job_t  rd_job;

  hrr_front #(
    .CHANNELS        (CHANNELS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample_left  (s_tdata[15:0]),
    .sample_right (s_tdata[31:16]),
    .step         (s_tdata[54:32]),
    .push         (push),
    .job          (wr_job),
    .full         (full)
  );

  hrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .full   (full),
    .pop    (pop),
    .valid  (job_valid),
    .rd_job (rd_job)
  );

  hrr_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_in    (rd_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_left  (m_tdata[15:0]),
    .out_right (m_tdata[31:16]),
    .run_end   (m_tlast)
  );

endmodule

>>> hw/rtl/hrr_checker.sv
`include "hermite_rate_resampler_defines.svh"

module hrr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // Count of frames taken, saturating once the history is primed.
  logic [1:0] seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (s_tvalid && s_tready && seen != 2'd3) begin
      seen <= seen + 2'd1;
    end
  end

  `HRR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `HRR_ASSERT_NEXT(a_reset_state, clk, 1'b0, rst, !m_tvalid && s_tready)
  `HRR_ASSERT_NOW(a_primed_first, clk, rst, m_tvalid, seen == 2'd3)

endmodule

bind hermite_rate_resampler hrr_checker u_hrr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
